// ===== rtl/core/gppm_pkg.sv =====
// Shared types and constants for the greedy pattern prefix matcher.
`default_nettype none
package gppm_pkg;

  localparam int unsigned NUM_CLASSES = 16;  // element kinds 1..16
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [4:0] KIND_LIT  = 5'd0;
  localparam logic [4:0] KIND_ANY  = 5'd1;
  localparam logic [4:0] KIND_LAST = 5'd16;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [1:0] {
    MOD_NONE = 2'd0,
    MOD_OPT  = 2'd1,
    MOD_STAR = 2'd2,
    MOD_PLUS = 2'd3
  } gppm_mod_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL
  } gppm_state_e;

  // One queued item: load fields plus the pre-classified text byte.
  typedef struct packed {
    logic                   mode;
    logic                   sot;
    logic [7:0]             chr;
    logic [NUM_CLASSES-1:0] cmask;
    logic [4:0]             idx;
    logic [4:0]             kind;
    logic [7:0]             lit;
    logic [1:0]             modf;
  } gppm_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/gppm_front.sv =====
// Front end: accepts items, classifies text bytes, holds the length register.
`default_nettype none
module gppm_front
  import gppm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic             full_i,
  input  wire logic             mode_i,
  input  wire logic             start_of_text_i,
  input  wire logic             end_of_text_i,
  input  wire logic [4:0]       element_index_i,
  input  wire logic [4:0]       element_kind_i,
  input  wire logic [7:0]       element_literal_i,
  input  wire logic [1:0]       element_modifier_i,
  input  wire logic [7:0]       text_char_i,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [5:0]       pat_len_o,
  output logic                  push_o,
  output gppm_item_t            item_o
);

  logic [5:0] plen_q, plen_d;
  logic [7:0] chr;

  function automatic logic [NUM_CLASSES-1:0] class_mask(input logic [7:0] c);
    logic alpha, digit, graph, lower, upper, xdig, alnum;
    logic [NUM_CLASSES-1:0] m;
    lower = (c >= 8'h61) && (c <= 8'h7A);
    upper = (c >= 8'h41) && (c <= 8'h5A);
    alpha = lower || upper;
    digit = (c >= 8'h30) && (c <= 8'h39);
    alnum = alpha || digit;
    graph = (c >= 8'h21) && (c <= 8'h7E);
    xdig  = digit || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    m[0]  = 1'b1;                                   // any
    m[1]  = alnum;
    m[2]  = alpha;
    m[3]  = !c[7];                                  // ascii
    m[4]  = (c == CH_SPACE) || (c == CH_TAB);       // blank
    m[5]  = (c < 8'h20) || (c == 8'h7F);            // cntrl
    m[6]  = digit;
    m[7]  = graph;
    m[8]  = alpha || (c == CH_UNDER);               // ident
    m[9]  = alnum || (c == CH_UNDER);               // idnum
    m[10] = lower;
    m[11] = (c >= 8'h20) && (c <= 8'h7E);           // print
    m[12] = graph && !alnum;                        // punct
    m[13] = (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    m[14] = upper;
    m[15] = xdig;
    return m;
  endfunction

  // end of text reads as NUL, and NUL is in no class
  assign chr = end_of_text_i ? 8'h00 : text_char_i;

  always_comb begin
    item_o.mode  = mode_i;
    item_o.sot   = start_of_text_i;
    item_o.chr   = chr;
    item_o.cmask = (chr == 8'h00) ? '0 : class_mask(chr);
    item_o.idx   = element_index_i;
    item_o.kind  = element_kind_i;
    item_o.lit   = element_literal_i;
    item_o.modf  = element_modifier_i;
  end

  assign push_o = start && !full_i;

  always_comb begin
    plen_d = plen_q;
    if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      plen_d = pwdata[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
    end else begin
      plen_q <= plen_d;
    end
  end

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? {26'd0, plen_q} : 32'd0;
  assign pat_len_o = plen_q;

endmodule
`default_nettype wire

// ===== rtl/core/gppm_fifo.sv =====
// Short item queue between front and back end.
`default_nettype none
module gppm_fifo
  import gppm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire gppm_item_t item_i,
  input  wire logic       pop_i,
  output logic            full_o,
  output logic            empty_o,
  output gppm_item_t      head_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  gppm_item_t       slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_q];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_d  = do_push ? bump(wr_q) : wr_q;
    rd_d  = do_pop ? bump(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gppm_back.sv =====
// Back end: pattern store and the element-walking match sequencer.
`default_nettype none
module gppm_back
  import gppm_pkg::*;
#(
  parameter int unsigned PATTERN_DEPTH = 32,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [5:0]             pat_len_i,
  input  wire logic                   empty_i,
  input  wire gppm_item_t             head_i,
  output logic                        pop_o,
  output logic                        done_o,
  output logic                        match_status_o,
  output logic [LENGTH_BITS-1:0]      match_length_o
);

  localparam int unsigned AW    = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int unsigned PTR_W = $clog2(PATTERN_DEPTH + 1);
  localparam int unsigned CW    = (PTR_W > 6) ? PTR_W : 6;
  localparam int unsigned IW    = (AW > 5) ? AW : 5;

  logic [14:0]            mem [PATTERN_DEPTH];
  logic [14:0]            rdata_q;
  gppm_state_e            state_q, state_d;
  gppm_item_t             cur_q, cur_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d, len;
  logic                   rep_q, rep_d, dec_q, dec_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d, cnt_inc, length_q, length_d;
  logic                   done_q, done_d, status_q, status_d;
  logic                   rd_en, wr_en;
  logic [CW-1:0]          plen_w, depth_w;
  logic [IW-1:0]          widx;
  logic [4:0]             kind, kind_m1;
  logic [7:0]             lit;
  logic [1:0]             modf;
  logic                   hit, adv;
  logic [PTR_W-1:0]       ptr_nx;

  assign plen_w  = CW'(pat_len_i);
  assign depth_w = CW'(PATTERN_DEPTH);
  assign len     = (plen_w > depth_w) ? depth_w[PTR_W-1:0] : plen_w[PTR_W-1:0];

  assign widx  = IW'(head_i.idx);
  assign wr_en = (state_q == ST_IDLE) && !empty_i && !head_i.mode &&
                 ({27'd0, head_i.idx} < 32'(PATTERN_DEPTH));

  assign kind    = rdata_q[14:10];
  assign lit     = rdata_q[9:2];
  assign modf    = rep_q ? MOD_STAR : rdata_q[1:0];
  assign kind_m1 = kind - 5'd1;
  assign hit     = (kind == KIND_LIT) ? ((cur_q.chr != 8'h00) && (cur_q.chr == lit))
                                      : cur_q.cmask[kind_m1[3:0]];
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + LENGTH_BITS'(1);
  assign adv     = !((modf == MOD_STAR) || (modf == MOD_PLUS));
  assign ptr_nx  = ptr_q + PTR_W'(1);

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    ptr_d    = ptr_q;
    rep_d    = rep_q;
    dec_d    = dec_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    status_d = status_q;
    length_d = length_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.mode) begin
            cur_d   = head_i;
            state_d = ST_CHECK;
            if (head_i.sot) begin
              ptr_d = '0;
              rep_d = 1'b0;
              cnt_d = '0;
              dec_d = 1'b0;
            end
          end
        end
      end
      ST_CHECK: begin
        if (dec_q) begin
          state_d = ST_IDLE;
        end else if (ptr_q >= len) begin
          done_d   = 1'b1;
          status_d = 1'b0;
          length_d = cnt_q;
          dec_d    = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        if (kind > KIND_LAST) begin
          done_d   = 1'b1;
          status_d = 1'b1;
          length_d = '0;
          dec_d    = 1'b1;
        end else if (hit) begin
          cnt_d = cnt_inc;
          rep_d = !adv;
          if (adv) begin
            ptr_d = ptr_nx;
          end
          if (adv && (ptr_nx >= len)) begin
            done_d   = 1'b1;
            status_d = 1'b0;
            length_d = cnt_inc;
            dec_d    = 1'b1;
          end
        end else if ((modf == MOD_OPT) || (modf == MOD_STAR)) begin
          // skip this element, retry the same byte on the next one
          ptr_d   = ptr_nx;
          rep_d   = 1'b0;
          state_d = ST_CHECK;
        end else begin
          done_d   = 1'b1;
          status_d = 1'b1;
          length_d = '0;
          dec_d    = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      rep_q   <= 1'b0;
      dec_q   <= 1'b1;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      rep_q   <= rep_d;
      dec_q   <= dec_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    status_q <= status_d;
    length_q <= length_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[widx[AW-1:0]] <= {head_i.kind, head_i.lit, head_i.modf};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[ptr_q[AW-1:0]];
    end
  end

  assign done_o         = done_q;
  assign match_status_o = status_q;
  assign match_length_o = length_q;

endmodule
`default_nettype wire

// ===== rtl/core/greedy_pattern_prefix_matcher.sv =====
// Top level: anchored greedy pattern prefix matcher.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  items in  | start / busy           | mode, start/end_of_text, element_*, text_char
//  results   | done_o strobe (1 cycle)| match_status_o, match_length_o
//  config    | APB psel/penable/pwrite| pattern_length at address 0
//
//  Items go into a two-entry queue; busy is high while the queue is full.
//  Back end: a load item takes the idle step only; a text item walks idle, check,
//  evaluate, plus check, evaluate per skipped optional or zero-or-more element,
//  ending at check if no match is in progress or pattern used up. One store read
//  per element tried. A result strobes in the cycle after the deciding step.
//  Reset clears control state; the pattern store is undefined until loaded.
`default_nettype none
module greedy_pattern_prefix_matcher
  import gppm_pkg::*;
#(
  parameter int unsigned PATTERN_DEPTH = 32,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   mode_i,
  input  wire logic                   start_of_text_i,
  input  wire logic                   end_of_text_i,
  input  wire logic [4:0]             element_index_i,
  input  wire logic [4:0]             element_kind_i,
  input  wire logic [7:0]             element_literal_i,
  input  wire logic [1:0]             element_modifier_i,
  input  wire logic [7:0]             text_char_i,
  output logic                        done_o,
  output logic                        match_status_o,
  output logic [LENGTH_BITS-1:0]      match_length_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);

  gppm_item_t item, head;
  logic       push, pop, full, empty;
  logic [5:0] pat_len;

  assign busy = full;

  gppm_front u_front (
    .clk_i,
    .rst_ni,
    .start,
    .full_i      (full),
    .mode_i,
    .start_of_text_i,
    .end_of_text_i,
    .element_index_i,
    .element_kind_i,
    .element_literal_i,
    .element_modifier_i,
    .text_char_i,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .pat_len_o   (pat_len),
    .push_o      (push),
    .item_o      (item)
  );

  gppm_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  gppm_back #(
    .PATTERN_DEPTH (PATTERN_DEPTH),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .pat_len_i      (pat_len),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .done_o,
    .match_status_o,
    .match_length_o
  );

endmodule
`default_nettype wire

// ===== rtl/core/gppm_checker.sv =====
// Port-level checks for the matcher, bound to the top level.
`default_nettype none
module gppm_checker #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   done_o,
  input wire logic                   match_status_o,
  input wire logic [LENGTH_BITS-1:0] match_length_o,
  input wire logic                   psel,
  input wire logic                   penable,
  input wire logic                   pwrite,
  input wire logic [2:0]             paddr,
  input wire logic [31:0]            pwdata,
  input wire logic [31:0]            prdata
);

  // a result strobe is never followed directly by another
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_fail_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && match_status_o) |-> (match_length_o == '0))
    else $error("failed match reports nonzero length");

  // the queue only fills after an item is taken
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

  a_cfg_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) |=>
      ((prdata[5:0] == $past(pwdata[5:0])) && (prdata[31:6] == '0) || paddr[2]))
    else $error("pattern length readback mismatch");

endmodule

bind greedy_pattern_prefix_matcher gppm_checker #(.LENGTH_BITS(LENGTH_BITS)) u_gppm_chk (.*);
`default_nettype wire
